@@ hw/rtl/brel_pkg.sv @@
// Shared types, constants and helper functions for the box relation unit.
`default_nettype none

package brel_pkg;

    localparam int CELL_BITS = 32;
    localparam int SPAN_W    = CELL_BITS + 1;
    localparam int PROD_W    = (2 * SPAN_W > 65) ? 2 * SPAN_W : 65;
    localparam int IN_W      = 328;
    localparam int OUT_W     = 200;

    typedef logic signed [CELL_BITS-1:0] cell_t;

    localparam cell_t CELL_MAX = {1'b0, {(CELL_BITS-1){1'b1}}};

    typedef enum logic [3:0] {
        ACT_CONTAINS      = 4'd0,
        ACT_WRAP_CONTAINS = 4'd1,
        ACT_OVERLAPS      = 4'd2,
        ACT_WRAP_OVERLAPS = 4'd3,
        ACT_CONTAINS_BOX  = 4'd4,
        ACT_INTERSECT     = 4'd5,
        ACT_CAN_FUSE      = 4'd6,
        ACT_TESSELLATE    = 4'd7,
        ACT_SIZE          = 4'd8
    } act_t;

    typedef struct packed {
        cell_t bx;
        cell_t by;
        cell_t ex;
        cell_t ey;
    } box_t;

    typedef struct packed {
        act_t  action;
        box_t  a;
        box_t  b;
        cell_t px;
        cell_t py;
    } item_t;

    typedef struct packed {
        logic        flag;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [63:0] count;
    } result_t;

    // Sign-extend the 32-bit field, then keep the low cell bits.
    function automatic cell_t to_cell(logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[CELL_BITS-1:0];
    endfunction

    // Sign-extend a cell value and keep the low 32 bits for the port.
    function automatic logic [31:0] out32(cell_t v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/brel_ops.sv @@
// Flag and result box logic for all box relation actions.
`default_nettype none

module brel_ops (
    input  wire brel_pkg::item_t item,
    output logic                 flag,
    output brel_pkg::box_t       box
);

    function automatic logic in1(brel_pkg::cell_t b, brel_pkg::cell_t e,
                                 brel_pkg::cell_t p);
        return (p >= b) && (p <= e);
    endfunction

    function automatic logic wrap_in1(brel_pkg::cell_t b, brel_pkg::cell_t e,
                                      brel_pkg::cell_t p);
        return (b > e) ? ((p >= b) || (p <= e)) : ((p >= b) && (p <= e));
    endfunction

    function automatic logic ovl1(brel_pkg::cell_t ab, brel_pkg::cell_t ae,
                                  brel_pkg::cell_t bb, brel_pkg::cell_t be);
        return !((ab > be) || (bb > ae));
    endfunction

    // Only A may wrap; a wrapped A misses B only when B sits in its gap.
    function automatic logic wrap_ovl1(brel_pkg::cell_t ab, brel_pkg::cell_t ae,
                                       brel_pkg::cell_t bb, brel_pkg::cell_t be);
        return (ab > ae) ? !((ab > be) && (bb > ae)) : !((ab > be) || (bb > ae));
    endfunction

    function automatic brel_pkg::cell_t inc_sat(brel_pkg::cell_t v);
        return (v == brel_pkg::CELL_MAX) ? brel_pkg::CELL_MAX : v + brel_pkg::cell_t'(1);
    endfunction

    function automatic logic touch1(brel_pkg::cell_t ab, brel_pkg::cell_t ae,
                                    brel_pkg::cell_t bb, brel_pkg::cell_t be,
                                    logic ov);
        return ov || (inc_sat(ae) == bb) || (inc_sat(be) == ab);
    endfunction

    brel_pkg::cell_t abx, aby, aex, aey;
    brel_pkg::cell_t bbx, bby, bex, bey;
    brel_pkg::cell_t px, py;
    logic            ov;
    logic            same_x;
    logic            same_y;
    brel_pkg::cell_t bex_inc, bey_inc, bbx_dec, bby_dec;

    always_comb
    begin
        abx = item.a.bx;
        aby = item.a.by;
        aex = item.a.ex;
        aey = item.a.ey;
        bbx = item.b.bx;
        bby = item.b.by;
        bex = item.b.ex;
        bey = item.b.ey;
        px  = item.px;
        py  = item.py;

        ov      = ovl1(abx, aex, bbx, bex) && ovl1(aby, aey, bby, bey);
        same_x  = (abx == bbx) && (aex == bex);
        same_y  = (aby == bby) && (aey == bey);
        // Only used where B lies strictly past the point, so no wrap.
        bex_inc = bex + brel_pkg::cell_t'(1);
        bey_inc = bey + brel_pkg::cell_t'(1);
        bbx_dec = bbx - brel_pkg::cell_t'(1);
        bby_dec = bby - brel_pkg::cell_t'(1);

        flag = 1'b0;
        box  = '0;

        case (item.action)
            brel_pkg::ACT_CONTAINS:
            begin
                flag = in1(abx, aex, px) && in1(aby, aey, py);
            end
            brel_pkg::ACT_WRAP_CONTAINS:
            begin
                flag = wrap_in1(abx, aex, px) && wrap_in1(aby, aey, py);
            end
            brel_pkg::ACT_OVERLAPS:
            begin
                flag = ov;
            end
            brel_pkg::ACT_WRAP_OVERLAPS:
            begin
                flag = wrap_ovl1(abx, aex, bbx, bex) && wrap_ovl1(aby, aey, bby, bey);
            end
            brel_pkg::ACT_CONTAINS_BOX:
            begin
                flag = in1(abx, aex, bbx) && in1(aby, aey, bby)
                    && in1(abx, aex, bex) && in1(aby, aey, bey);
            end
            brel_pkg::ACT_INTERSECT:
            begin
                flag = ov;
                if (ov)
                begin
                    box.bx = (abx > bbx) ? abx : bbx;
                    box.by = (aby > bby) ? aby : bby;
                    box.ex = (aex < bex) ? aex : bex;
                    box.ey = (aey < bey) ? aey : bey;
                end
            end
            brel_pkg::ACT_CAN_FUSE:
            begin
                if (!same_x)
                    flag = touch1(abx, aex, bbx, bex, ov) && same_y;
                else if (!same_y)
                    flag = touch1(aby, aey, bby, bey, ov);
                else
                    flag = 1'b0;
            end
            brel_pkg::ACT_TESSELLATE:
            begin
                flag = ov;
                box  = item.a;
                if (ov)
                begin
                    if ((bex < px) && (bex_inc > abx))
                        box.bx = bex_inc;
                    if ((bbx > px) && (bbx_dec < aex))
                        box.ex = bbx_dec;
                    if ((bey < py) && (bey_inc > aby))
                        box.by = bey_inc;
                    if ((bby > py) && (bby_dec < aey))
                        box.ey = bby_dec;
                end
            end
            default:
            begin
                flag = 1'b0;
                box  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/brel_count.sv @@
// Saturating cell count of box A for the size action.
`default_nettype none

module brel_count (
    input  wire brel_pkg::item_t item,
    output logic [63:0]          count
);

    logic [brel_pkg::CELL_BITS-1:0] dx;
    logic [brel_pkg::CELL_BITS-1:0] dy;
    logic [brel_pkg::SPAN_W-1:0]    span_x;
    logic [brel_pkg::SPAN_W-1:0]    span_y;
    logic [brel_pkg::PROD_W-1:0]    prod;
    logic                           sat;

    always_comb
    begin
        // Span is taken modulo the cell range, then one is added.
        dx     = item.a.ex - item.a.bx;
        dy     = item.a.ey - item.a.by;
        span_x = {1'b0, dx} + brel_pkg::SPAN_W'(1);
        span_y = {1'b0, dy} + brel_pkg::SPAN_W'(1);
        prod   = brel_pkg::PROD_W'(span_x) * brel_pkg::PROD_W'(span_y);
        sat    = |prod[brel_pkg::PROD_W-1:64];
        if (item.action == brel_pkg::ACT_SIZE)
            count = sat ? {64{1'b1}} : prod[63:0];
        else
            count = '0;
    end

endmodule

`default_nettype wire

@@ hw/rtl/box_relation_unit_top.sv @@
// Top level of the box relation unit: input register, operation logic, result register.
//
//  Port group   Dir  Width  Contents
//  s_t*         in   328    action, box A, box B, point
//  m_t*         out  200    flag, result box, cell count
//
//  One request is taken per cycle unless m_t* stalls; the result register drives m_t*.
//  Latency and rate are set by the input register and the result register,
//  with all operation logic (one 33x33 multiply for the count) between them.
//  rst_n clears both valid bits; payload registers are not reset.
//  A stalled result holds the result register, and the input register
//  keeps taking requests until it also fills.
`default_nettype none

module box_relation_unit_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // action[3:0], a_beg_x, a_beg_y, a_end_x, a_end_y, b_beg_x, b_beg_y,
    // b_end_x, b_end_y, point_x, point_y (32 each), zero pad [327:324]
    input  wire logic [brel_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // flag[0], box_beg_x, box_beg_y, box_end_x, box_end_y (32 each),
    // cell_count (64), zero pad [199:193]
    output logic [brel_pkg::OUT_W-1:0]      m_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    brel_pkg::item_t   item_reg;
    brel_pkg::item_t   item_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    brel_pkg::result_t res_reg;
    brel_pkg::result_t res_next;

    logic              in_ready;
    logic              in_load;
    logic              out_adv;
    logic              op_flag;
    brel_pkg::box_t    op_box;
    logic [63:0]       op_count;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_ready = !in_valid_reg || out_adv;
    assign in_load  = s_tvalid && in_ready;

    always_comb
    begin
        item_next.action = brel_pkg::act_t'(s_tdata[3:0]);
        item_next.a.bx   = brel_pkg::to_cell(s_tdata[35:4]);
        item_next.a.by   = brel_pkg::to_cell(s_tdata[67:36]);
        item_next.a.ex   = brel_pkg::to_cell(s_tdata[99:68]);
        item_next.a.ey   = brel_pkg::to_cell(s_tdata[131:100]);
        item_next.b.bx   = brel_pkg::to_cell(s_tdata[163:132]);
        item_next.b.by   = brel_pkg::to_cell(s_tdata[195:164]);
        item_next.b.ex   = brel_pkg::to_cell(s_tdata[227:196]);
        item_next.b.ey   = brel_pkg::to_cell(s_tdata[259:228]);
        item_next.px     = brel_pkg::to_cell(s_tdata[291:260]);
        item_next.py     = brel_pkg::to_cell(s_tdata[323:292]);
    end

    brel_ops u_ops (
        .item (item_reg),
        .flag (op_flag),
        .box  (op_box)
    );

    brel_count u_count (
        .item  (item_reg),
        .count (op_count)
    );

    always_comb
    begin
        res_next.flag  = op_flag;
        res_next.bx    = brel_pkg::out32(op_box.bx);
        res_next.by    = brel_pkg::out32(op_box.by);
        res_next.ex    = brel_pkg::out32(op_box.ex);
        res_next.ey    = brel_pkg::out32(op_box.ey);
        res_next.count = op_count;
    end

    always_comb
    begin
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        out_valid_next = out_adv ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            item_reg <= item_next;
        if (out_adv && in_valid_reg)
            res_reg <= res_next;
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.count, res_reg.ey, res_reg.ex,
                       res_reg.by, res_reg.bx, res_reg.flag};

`ifndef SYNTHESIS
    // A count only comes from the size action, which has no flag and no box.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.count != 64'd0)) |->
            (!res_reg.flag && (res_reg.bx == 32'd0) && (res_reg.by == 32'd0)
             && (res_reg.ex == 32'd0) && (res_reg.ey == 32'd0)))
        else $error("cell count set together with flag or box");

    // Backpressure reaches the input only when both stages are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with a free stage");

    // A held request moves into the result register when it advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("request lost between stages");

    // The result register is filled only from a valid input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_adv && !in_valid_reg) |=> !out_valid_reg)
        else $error("result produced without a request");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_box_relation_unit_top.sv @@
// Self-checking testbench for box_relation_unit_top: directed table plus random requests.
`default_nettype none

module tb_box_relation_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 23;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 80;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

    localparam logic [63:0] CELL_MASK = (brel_pkg::CELL_BITS == 64) ? '1 :
                                        ((64'd1 << brel_pkg::CELL_BITS) - 64'd1);
    localparam longint      CELL_TOP  = longint'(CELL_MASK >> 1);

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] abx;
        logic signed [31:0] aby;
        logic signed [31:0] aex;
        logic signed [31:0] aey;
        logic signed [31:0] bbx;
        logic signed [31:0] bby;
        logic signed [31:0] bex;
        logic signed [31:0] bey;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } relation_item_t;

    typedef struct packed {
        relation_item_t    req;
        logic              typed;
        brel_pkg::result_t want;
    } stim_row_t;

    // Rows with typed set carry their answer; the rest go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{brel_pkg::ACT_CONTAINS, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
            0, 0, 0, 0, COORD_MIN, COORD_MIN}, 1'b0, '0},
        '{'{brel_pkg::ACT_CONTAINS, -4, -4, 4, 4, 0, 0, 0, 0, 5, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_WRAP_CONTAINS, 10, COORD_MIN, -10, COORD_MAX, 0, 0, 0, 0,
            COORD_MAX, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_WRAP_CONTAINS, 10, COORD_MIN, -10, COORD_MAX, 0, 0, 0, 0,
            0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_OVERLAPS, 0, 0, 5, 5, 5, 5, 9, 9, 0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_OVERLAPS, 0, 0, 5, 5, 6, 0, 9, 5, 0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_WRAP_OVERLAPS, COORD_MAX - 2, 0, COORD_MIN + 2, 5,
            COORD_MIN, 3, COORD_MIN, 3, 0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_CONTAINS_BOX, -10, -10, 10, 10, -10, -10, 10, 10, 0, 0},
            1'b0, '0},
        '{'{brel_pkg::ACT_INTERSECT, 0, 0, 9, 9, 5, 5, 20, 20, 0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_INTERSECT, 0, 0, 3, 3, 4, 0, 8, 3, 0, 0}, 1'b1, '0},
        '{'{brel_pkg::ACT_CAN_FUSE, 0, 0, 3, 5, 4, 0, 7, 5, 0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_CAN_FUSE, 1, 2, 3, 4, 1, 2, 3, 4, 0, 0}, 1'b1, '0},
        '{'{brel_pkg::ACT_CAN_FUSE, 0, 0, COORD_MAX, 5, COORD_MAX, 0, COORD_MIN, 5,
            0, 0}, 1'b0, '0},
        '{'{brel_pkg::ACT_TESSELLATE, 0, 0, 20, 20, 5, 5, 8, 8, 10, 2}, 1'b0, '0},
        '{'{brel_pkg::ACT_TESSELLATE, 0, 0, 9, 9, 3, 3, 5, 5, -20, 30}, 1'b0, '0},
        '{'{brel_pkg::ACT_TESSELLATE, 0, 0, 3, 3, 10, 10, 12, 12, 1, 1}, 1'b1,
            '{1'b0, 32'd0, 32'd0, 32'd3, 32'd3, 64'd0}},
        '{'{brel_pkg::ACT_TESSELLATE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
            COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MAX}, 1'b0, '0},
        '{'{brel_pkg::ACT_SIZE, 7, -3, 7, -3, 0, 0, 0, 0, 0, 0}, 1'b1,
            '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd1}},
        '{'{brel_pkg::ACT_SIZE, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
            0, 0, 0, 0, 0, 0}, 1'b1,
            '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, '1}},
        '{'{brel_pkg::ACT_SIZE, 5, 0, 4, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
            '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 64'h1_0000_0000}},
        '{'{4'd9, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, '0},
        '{'{4'd15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '0},
        '{'{brel_pkg::ACT_CONTAINS, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
            1'b0, '0}
    };

    logic                        clk;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [brel_pkg::IN_W-1:0]   s_tdata  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [brel_pkg::OUT_W-1:0]  m_tdata;

    brel_pkg::result_t pending_results[$];
    int                mismatches     = 0;
    int                requests_taken = 0;
    int                results_seen   = 0;
    int                cycle_count    = 0;

    box_relation_unit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sign-extend a port coordinate, then fold it to the cell width.
    function automatic longint cell_of(logic [31:0] f);
        longint w;
        w = longint'($signed(f));
        if (brel_pkg::CELL_BITS < 64)
        begin
            w = (w <<< (64 - brel_pkg::CELL_BITS)) >>> (64 - brel_pkg::CELL_BITS);
        end
        return w;
    endfunction

    function automatic bit in_span(longint b, longint e, longint p);
        return p >= b && p <= e;
    endfunction

    function automatic bit wrap_in_span(longint b, longint e, longint p);
        return (b > e) ? (p >= b || p <= e) : (p >= b && p <= e);
    endfunction

    function automatic bit overlap1(longint ab, longint ae, longint bb, longint be);
        return !(ab > be || bb > ae);
    endfunction

    function automatic bit wrap_overlap1(longint ab, longint ae, longint bb, longint be);
        if (ab > ae)
        begin
            return !(ab > be && bb > ae);
        end
        return overlap1(ab, ae, bb, be);
    endfunction

    function automatic longint bump_sat(longint v);
        return (v >= CELL_TOP) ? CELL_TOP : v + 1;
    endfunction

    function automatic bit touch1(longint ab, longint ae, longint bb, longint be, bit ov);
        return ov || bump_sat(ae) == bb || bump_sat(be) == ab;
    endfunction

    function automatic logic [63:0] cell_span(longint b, longint e);
        logic [63:0] d;
        d = (64'(e) - 64'(b)) & CELL_MASK;
        return (d == '1) ? '1 : d + 64'd1;
    endfunction

    function automatic brel_pkg::result_t predict_relation(relation_item_t it);
        longint            abx, aby, aex, aey, bbx, bby, bex, bey, px, py;
        longint            rbx, rby, rex, rey;
        bit                ov, same_x, same_y;
        logic [127:0]      prod;
        brel_pkg::result_t r;
        abx = cell_of(it.abx); aby = cell_of(it.aby);
        aex = cell_of(it.aex); aey = cell_of(it.aey);
        bbx = cell_of(it.bbx); bby = cell_of(it.bby);
        bex = cell_of(it.bex); bey = cell_of(it.bey);
        px  = cell_of(it.px);  py  = cell_of(it.py);
        r = '0;
        rbx = 0; rby = 0; rex = 0; rey = 0;
        ov = overlap1(abx, aex, bbx, bex) && overlap1(aby, aey, bby, bey);
        case (it.action)
            brel_pkg::ACT_CONTAINS:
                r.flag = in_span(abx, aex, px) && in_span(aby, aey, py);
            brel_pkg::ACT_WRAP_CONTAINS:
                r.flag = wrap_in_span(abx, aex, px) && wrap_in_span(aby, aey, py);
            brel_pkg::ACT_OVERLAPS:
                r.flag = ov;
            brel_pkg::ACT_WRAP_OVERLAPS:
                r.flag = wrap_overlap1(abx, aex, bbx, bex)
                      && wrap_overlap1(aby, aey, bby, bey);
            brel_pkg::ACT_CONTAINS_BOX:
                r.flag = in_span(abx, aex, bbx) && in_span(aby, aey, bby)
                      && in_span(abx, aex, bex) && in_span(aby, aey, bey);
            brel_pkg::ACT_INTERSECT:
            begin
                r.flag = ov;
                if (ov)
                begin
                    rbx = (abx > bbx) ? abx : bbx;
                    rby = (aby > bby) ? aby : bby;
                    rex = (aex < bex) ? aex : bex;
                    rey = (aey < bey) ? aey : bey;
                end
            end
            brel_pkg::ACT_CAN_FUSE:
            begin
                same_x = abx == bbx && aex == bex;
                same_y = aby == bby && aey == bey;
                if (!same_x)
                begin
                    r.flag = touch1(abx, aex, bbx, bex, ov) && same_y;
                end
                else if (!same_y)
                begin
                    r.flag = touch1(aby, aey, bby, bey, ov);
                end
            end
            brel_pkg::ACT_TESSELLATE:
            begin
                rbx = abx; rby = aby; rex = aex; rey = aey;
                r.flag = ov;
                // Pull each side of A in past B, on the side away from the anchor.
                if (ov)
                begin
                    if (bex < px && bex + 1 > rbx) rbx = bex + 1;
                    if (bbx > px && bbx - 1 < rex) rex = bbx - 1;
                    if (bey < py && bey + 1 > rby) rby = bey + 1;
                    if (bby > py && bby - 1 < rey) rey = bby - 1;
                end
            end
            brel_pkg::ACT_SIZE:
            begin
                prod = {64'd0, cell_span(abx, aex)} * {64'd0, cell_span(aby, aey)};
                r.count = (|prod[127:64]) ? '1 : prod[63:0];
            end
            default:
                r = '0;
        endcase
        r.bx = rbx[31:0];
        r.by = rby[31:0];
        r.ex = rex[31:0];
        r.ey = rey[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] coord_near(logic signed [31:0] base);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom;
        end
        return base + 32'($urandom_range(0, 16)) - 32'sd8;
    endfunction

    // Mostly ordered boxes clustered around a shared base so that relations often hold.
    function automatic relation_item_t random_item();
        relation_item_t     it;
        logic signed [31:0] base;
        int                 k;
        k = $urandom_range(0, 9);
        base = (k < 6) ? 32'sd0 : (k == 6) ? COORD_MAX - 32'sd8 :
               (k == 7) ? COORD_MIN + 32'sd8 : $urandom;
        k = $urandom_range(0, 99);
        it.action = (k < 95) ? 4'(k % 9) : 4'($urandom_range(9, 15));
        it.abx = coord_near(base); it.aby = coord_near(base);
        it.aex = coord_near(base); it.aey = coord_near(base);
        it.bbx = coord_near(base); it.bby = coord_near(base);
        it.bex = coord_near(base); it.bey = coord_near(base);
        it.px  = coord_near(base); it.py  = coord_near(base);
        if ($urandom_range(0, 4) != 0)
        begin
            if ($signed(it.abx) > $signed(it.aex)) {it.abx, it.aex} = {it.aex, it.abx};
            if ($signed(it.aby) > $signed(it.aey)) {it.aby, it.aey} = {it.aey, it.aby};
            if ($signed(it.bbx) > $signed(it.bex)) {it.bbx, it.bex} = {it.bex, it.bbx};
            if ($signed(it.bby) > $signed(it.bey)) {it.bby, it.bey} = {it.bey, it.bby};
        end
        if (it.action == brel_pkg::ACT_CAN_FUSE && $urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                {it.bby, it.bey} = {it.aby, it.aey};
            end
            else
            begin
                {it.bbx, it.bex} = {it.abx, it.aex};
            end
        end
        return it;
    endfunction

    task automatic note_mismatch(string msg);
        $display("tb: mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        brel_pkg::result_t got;
        brel_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[96:65],
                    m_tdata[128:97], m_tdata[192:129]};
            if (pending_results.size() == 0)
            begin
                note_mismatch("result with no request pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.flag !== want.flag)
                    note_mismatch($sformatf("flag %0b, want %0b", got.flag, want.flag));
                if (got.bx !== want.bx)
                    note_mismatch($sformatf("box_beg_x %h, want %h", got.bx, want.bx));
                if (got.by !== want.by)
                    note_mismatch($sformatf("box_beg_y %h, want %h", got.by, want.by));
                if (got.ex !== want.ex)
                    note_mismatch($sformatf("box_end_x %h, want %h", got.ex, want.ex));
                if (got.ey !== want.ey)
                    note_mismatch($sformatf("box_end_y %h, want %h", got.ey, want.ey));
                if (got.count !== want.count)
                    note_mismatch($sformatf("cell_count %h, want %h",
                                            got.count, want.count));
            end
            results_seen++;
        end
    end

    // Output side: random ready runs and stalls, plus one long hold-off to back up the input.
    initial
    begin : result_sink
        bit long_hold_done;
        int k;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            k = $urandom_range(0, 99);
            if (!long_hold_done && requests_taken >= NUM_DIRECTED + 150)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (k < 60)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            else if (k < 68)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 150)) @(negedge clk);
            end
            else if (k < 95)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(negedge clk);
            end
        end
    end

    initial
    begin : request_source
        relation_item_t    it;
        brel_pkg::result_t want;
        int                gap;
        int                k;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        for (int n = 0; n < NUM_DIRECTED + RANDOM_ITEMS; n++)
        begin
            it = (n < NUM_DIRECTED) ? DIRECTED_ROWS[n].req : random_item();
            k = $urandom_range(0, 99);
            gap = (k < 70) ? 0 : (k < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            // Keep a back-to-back stretch with no sender gaps.
            if (n >= NUM_DIRECTED + 400 && n < NUM_DIRECTED + 500)
            begin
                gap = 0;
            end
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'd0, it.py, it.px, it.bey, it.bex, it.bby, it.bbx,
                         it.aey, it.aex, it.aby, it.abx, it.action};
            do
            begin
                @(posedge clk);
            end
            while (!s_tready);
            if (n < NUM_DIRECTED && DIRECTED_ROWS[n].typed)
            begin
                want = DIRECTED_ROWS[n].want;
            end
            else
            begin
                want = predict_relation(it);
            end
            pending_results.push_back(want);
            requests_taken++;
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/brel_pkg.sv
hw/rtl/brel_ops.sv
hw/rtl/brel_count.sv
hw/rtl/box_relation_unit_top.sv
tb/sv/tb_box_relation_unit_top.sv
